>>> hw/rtl/dlw_pkg.sv
// dlw_pkg: shared constants for the lattice walker
// status codes, register indexes, field widths and reset values
// no dependencies
`default_nettype none

package dlw_pkg;

  localparam int SIDE_DEFAULT = 128;

  localparam int COORD_W    = 7;
  localparam int STATUS_W   = 3;
  localparam int RADIUS_W   = 7;
  localparam int START_W    = 6;
  localparam int INTERVAL_W = 16;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [START_W-1:0]    DEF_START_RADIUS    = 6'd10;
  localparam logic [INTERVAL_W-1:0] DEF_GROWTH_INTERVAL = 16'd300;

  localparam logic [STATUS_W-1:0] STAT_MOVING   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_STUCK    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_ESCAPED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BLOCKED  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_LAUNCHED = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_IDLE     = 3'd5;

  localparam logic OP_LAUNCH = 1'b0;
  localparam logic OP_STEP   = 1'b1;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic REG_START_RADIUS    = 1'b0;
  localparam logic REG_GROWTH_INTERVAL = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/dla_lattice_walker.sv
// dla_lattice_walker: one walker of a diffusion limited aggregation lattice
// launch: one row checked per transaction; step: three rows
// read over the two read ports of dlw_lattice, then, if the walker sticks, one row written back
// result registered; a stalled result holds the sequencer in its last state
// reset: registers at once, then a clearing sweep rewrites every one of the SIDE lattice
// rows (128 by default) and seeds the centre; no input meanwhile
`default_nettype none

module dla_lattice_walker #(
  parameter int SIDE = dlw_pkg::SIDE_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dlw_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [dlw_pkg::DATA_W-1:0]     pwdata,
  output logic      [dlw_pkg::DATA_W-1:0]     prdata,
  output logic                                pready,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           op,
  input  wire logic [dlw_pkg::COORD_W-1:0]    pos_x,
  input  wire logic [dlw_pkg::COORD_W-1:0]    pos_y,
  input  wire logic [1:0]                     direction,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [dlw_pkg::STATUS_W-1:0]   status,
  output logic      [dlw_pkg::COORD_W-1:0]    walker_col,
  output logic      [dlw_pkg::COORD_W-1:0]    walker_row,
  output logic      [dlw_pkg::RADIUS_W-1:0]   launch_radius
);

  localparam int CW  = dlw_pkg::COORD_W;
  localparam int AW  = $clog2(SIDE);
  localparam int XW  = $clog2(SIDE);
  localparam int RW  = dlw_pkg::RADIUS_W;
  localparam int SW  = dlw_pkg::START_W;
  localparam int IW  = dlw_pkg::INTERVAL_W;
  localparam int EXT = (SIDE < 128) ? SIDE : 128;
  localparam logic [CW:0]   EXT_C   = (CW + 1)'(EXT);
  localparam logic [CW:0]   LAST_C  = (CW + 1)'(EXT - 1);
  localparam logic [RW-1:0] MAX_RAD = RW'(EXT / 2);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LAUNCH = 2'd1;
  localparam logic [1:0] ST_STEP1  = 2'd2;
  localparam logic [1:0] ST_STEP2  = 2'd3;

  function automatic logic in_ext(input logic [CW-1:0] x, input logic [CW-1:0] y);
    in_ext = ({1'b0, x} < EXT_C) && ({1'b0, y} < EXT_C);
  endfunction

  function automatic logic on_border(input logic [CW-1:0] x, input logic [CW-1:0] y);
    on_border = (x == '0) || (y == '0) || ({1'b0, x} >= LAST_C) || ({1'b0, y} >= LAST_C);
  endfunction

  function automatic logic row_bit(input logic [SIDE-1:0] row, input logic [CW-1:0] x,
                                   input logic [CW-1:0] y);
    row_bit = in_ext(x, y) && row[XW'(x)];
  endfunction

  function automatic logic [SIDE-1:0] set_bit(input logic [SIDE-1:0] row,
                                              input logic [CW-1:0] x);
    set_bit = row | (SIDE'(1) << XW'(x));
  endfunction

  logic [1:0]      state, state_next;
  logic [SW-1:0]   start_radius;
  logic [IW-1:0]   growth_interval;
  logic [RW-1:0]   radius, radius_next;
  logic [IW-1:0]   launch_count, launch_count_next;
  logic [CW-1:0]   walker_x, walker_x_next;
  logic [CW-1:0]   walker_y, walker_y_next;
  logic            walker_active, walker_active_next;

  logic [CW-1:0]   px, py, nx, ny;
  logic [1:0]      dir;
  logic [CW-1:0]   nx_in, ny_in;
  logic [SIDE-1:0] row_lo;

  logic            clearing;
  logic            lat_we;
  logic [AW-1:0]   lat_waddr;
  logic [SIDE-1:0] lat_wdata;
  logic            rd_en_a, rd_en_b;
  logic [AW-1:0]   rd_addr_a, rd_addr_b;
  logic [SIDE-1:0] rd_data_a, rd_data_b;

  logic            accept, finish, cfg_wr;
  logic [dlw_pkg::STATUS_W-1:0] status_next;
  logic [SIDE-1:0] old_row;
  logic            neigh;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state == ST_IDLE) && !clearing;
  assign accept   = in_valid && in_ready;
  assign finish   = !out_valid || out_ready;

  always_comb begin
    if (paddr[2] == dlw_pkg::REG_START_RADIUS) begin
      prdata = dlw_pkg::DATA_W'(start_radius);
    end else begin
      prdata = dlw_pkg::DATA_W'(growth_interval);
    end
  end

  always_comb begin
    nx_in = walker_x;
    ny_in = walker_y;
    unique case (direction)
      dlw_pkg::DIR_UP:    ny_in = walker_y + CW'(1);
      dlw_pkg::DIR_RIGHT: nx_in = walker_x + CW'(1);
      dlw_pkg::DIR_DOWN:  ny_in = walker_y - CW'(1);
      dlw_pkg::DIR_LEFT:  nx_in = walker_x - CW'(1);
    endcase
  end

  always_comb begin
    rd_en_a   = 1'b0;
    rd_en_b   = 1'b0;
    rd_addr_a = (op == dlw_pkg::OP_LAUNCH) ? AW'(pos_y) : AW'(ny_in);
    rd_addr_b = AW'(ny_in - CW'(1));
    if (accept) begin
      rd_en_a = 1'b1;
      rd_en_b = 1'b1;
    end else if (state == ST_STEP1) begin
      rd_en_b   = 1'b1;
      rd_addr_b = AW'(ny + CW'(1));
    end
  end

  always_comb begin
    unique case (dir)
      dlw_pkg::DIR_UP:   old_row = row_lo;
      dlw_pkg::DIR_DOWN: old_row = rd_data_b;
      default:           old_row = rd_data_a;
    endcase
  end

  assign neigh = row_bit(rd_data_a, nx - CW'(1), ny) || row_bit(rd_data_a, nx + CW'(1), ny) ||
                 row_bit(row_lo, nx, ny - CW'(1)) || row_bit(rd_data_b, nx, ny + CW'(1));

  always_comb begin
    state_next         = state;
    radius_next        = radius;
    launch_count_next  = launch_count;
    walker_x_next      = walker_x;
    walker_y_next      = walker_y;
    walker_active_next = walker_active;
    status_next        = dlw_pkg::STAT_IDLE;
    lat_we             = 1'b0;
    lat_waddr          = AW'(ny);
    lat_wdata          = set_bit(rd_data_a, nx);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (op == dlw_pkg::OP_LAUNCH) ? ST_LAUNCH : ST_STEP1;
        end
      end
      ST_LAUNCH: begin
        walker_x_next = px;
        walker_y_next = py;
        if (on_border(px, py) || row_bit(rd_data_a, px, py)) begin
          walker_active_next = 1'b0;
          status_next        = dlw_pkg::STAT_BLOCKED;
        end else begin
          walker_active_next = 1'b1;
          status_next        = dlw_pkg::STAT_LAUNCHED;
        end
        launch_count_next = launch_count + IW'(1);
        if ((growth_interval != '0) && (launch_count_next >= growth_interval)) begin
          launch_count_next = '0;
          if (radius < MAX_RAD) begin
            radius_next = radius + RW'(1);
          end
        end
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      ST_STEP1: begin
        state_next = ST_STEP2;
      end
      ST_STEP2: begin
        priority if (!walker_active) begin
          status_next = dlw_pkg::STAT_IDLE;
        end else if (row_bit(rd_data_a, nx, ny)) begin
          lat_we             = finish;
          lat_waddr          = AW'(walker_y);
          lat_wdata          = set_bit(old_row, walker_x);
          walker_active_next = 1'b0;
          status_next        = dlw_pkg::STAT_STUCK;
        end else if (on_border(nx, ny)) begin
          walker_x_next      = nx;
          walker_y_next      = ny;
          walker_active_next = 1'b0;
          status_next        = dlw_pkg::STAT_ESCAPED;
        end else begin
          walker_x_next = nx;
          walker_y_next = ny;
          if (neigh) begin
            lat_we             = finish;
            walker_active_next = 1'b0;
            status_next        = dlw_pkg::STAT_STUCK;
          end else begin
            status_next = dlw_pkg::STAT_MOVING;
          end
        end
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      start_radius    <= dlw_pkg::DEF_START_RADIUS;
      growth_interval <= dlw_pkg::DEF_GROWTH_INTERVAL;
      radius          <= RW'(dlw_pkg::DEF_START_RADIUS);
      launch_count    <= '0;
      walker_x        <= '0;
      walker_y        <= '0;
      walker_active   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr && (paddr[2] == dlw_pkg::REG_START_RADIUS)) begin
        start_radius <= pwdata[SW-1:0];
        radius       <= (pwdata[SW-1:0] == '0) ? RW'(1) : RW'(pwdata[SW-1:0]);
      end else if (cfg_wr && (paddr[2] == dlw_pkg::REG_GROWTH_INTERVAL)) begin
        growth_interval <= pwdata[IW-1:0];
      end
      if (((state == ST_LAUNCH) || (state == ST_STEP2)) && finish) begin
        radius        <= radius_next;
        launch_count  <= launch_count_next;
        walker_x      <= walker_x_next;
        walker_y      <= walker_y_next;
        walker_active <= walker_active_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px  <= pos_x;
      py  <= pos_y;
      nx  <= nx_in;
      ny  <= ny_in;
      dir <= direction;
    end
    if (state == ST_STEP1) begin
      row_lo <= rd_data_b;
    end
    if (((state == ST_LAUNCH) || (state == ST_STEP2)) && finish) begin
      status        <= status_next;
      walker_col    <= walker_x_next;
      walker_row    <= walker_y_next;
      launch_radius <= radius_next;
    end
  end

  dlw_lattice #(
    .SIDE(SIDE)
  ) u_lattice (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .we       (lat_we),
    .waddr    (lat_waddr),
    .wdata    (lat_wdata),
    .rd_en_a  (rd_en_a),
    .rd_addr_a(rd_addr_a),
    .rd_data_a(rd_data_a),
    .rd_en_b  (rd_en_b),
    .rd_addr_b(rd_addr_b),
    .rd_data_b(rd_data_b)
  );

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clearing |-> !in_ready
  ) else $error("transaction accepted during lattice clearing");

  a_step2_follows_step1: assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_STEP2) |-> ($past(state) == ST_STEP1 || $past(state) == ST_STEP2)
  ) else $error("step evaluation without row fetch");

  a_write_kills_walker: assert property (
    @(posedge clk) disable iff (rst) lat_we |=> !walker_active && out_valid
  ) else $error("lattice write without sticking walker");

  a_radius_nonzero: assert property (
    @(posedge clk) disable iff (rst) (radius != '0) && (radius <= MAX_RAD || !walker_active
      || radius <= RW'(dlw_pkg::DEF_START_RADIUS) || radius != '0)
  ) else $error("launch radius zero");

  a_launch_from_idle: assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_LAUNCH) |-> ($past(state) == ST_IDLE || $past(state) == ST_LAUNCH)
  ) else $error("launch evaluation without accepted transaction");

endmodule

`default_nettype wire

>>> hw/rtl/dlw_lattice.sv
// dlw_lattice: row-organised lattice memory, one row of cluster bits per word
// two registered read ports, one write port, clearing sweep after reset
// depends on dlw_pkg
`default_nettype none

module dlw_lattice #(
  parameter int SIDE = dlw_pkg::SIDE_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  output logic                         clearing,
  input  wire logic                    we,
  input  wire logic [$clog2(SIDE)-1:0] waddr,
  input  wire logic [SIDE-1:0]         wdata,
  input  wire logic                    rd_en_a,
  input  wire logic [$clog2(SIDE)-1:0] rd_addr_a,
  output logic      [SIDE-1:0]         rd_data_a,
  input  wire logic                    rd_en_b,
  input  wire logic [$clog2(SIDE)-1:0] rd_addr_b,
  output logic      [SIDE-1:0]         rd_data_b
);

  localparam int AW   = $clog2(SIDE);
  localparam int EXT  = (SIDE < 128) ? SIDE : 128;
  localparam int SEED = EXT / 2;
  localparam logic [AW-1:0]   SEED_ROW  = AW'(SEED);
  localparam logic [AW-1:0]   LAST_ROW  = AW'(SIDE - 1);
  localparam logic [SIDE-1:0] SEED_WORD = SIDE'(1) << SEED;

  logic [SIDE-1:0] mem [SIDE];
  logic [AW-1:0]   clr_row;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [SIDE-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + AW'(1);
      if (clr_row == LAST_ROW) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_row;
      mem_wdata = (clr_row == SEED_ROW) ? SEED_WORD : '0;
    end else begin
      mem_we    = we;
      mem_waddr = waddr;
      mem_wdata = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en_a) begin
      rd_data_a <= mem[rd_addr_a];
    end
    if (rd_en_b) begin
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for dla_lattice_walker with a lattice walker predictor
// directed table after reset, then walks with random content over several register settings
// depends on dlw_pkg and dla_lattice_walker
`timescale 1ns / 100ps

module tb_top;

  localparam int EXT = (dlw_pkg::SIDE_DEFAULT < 128) ? dlw_pkg::SIDE_DEFAULT : 128;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [dlw_pkg::STATUS_W-1:0] status;
    logic [dlw_pkg::COORD_W-1:0]  col;
    logic [dlw_pkg::COORD_W-1:0]  row;
    logic [dlw_pkg::RADIUS_W-1:0] radius;
  } walk_result_t;

  typedef struct packed {
    logic                        op;
    logic [dlw_pkg::COORD_W-1:0] x;
    logic [dlw_pkg::COORD_W-1:0] y;
    logic [1:0]                  dir;
    logic                        fixed;
    walk_result_t                res;
  } stim_row_t;

  localparam walk_result_t NO_FIXED = '0;

  localparam stim_row_t PLAN [26] = '{
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_UP,    1'b1,
      '{dlw_pkg::STAT_IDLE,    7'd0,   7'd0,   7'd10}},
    '{dlw_pkg::OP_LAUNCH, 7'd0,   7'd0,   dlw_pkg::DIR_UP,    1'b1,
      '{dlw_pkg::STAT_BLOCKED, 7'd0,   7'd0,   7'd10}},
    '{dlw_pkg::OP_LAUNCH, 7'd127, 7'd127, dlw_pkg::DIR_LEFT,  1'b1,
      '{dlw_pkg::STAT_BLOCKED, 7'd127, 7'd127, 7'd10}},
    '{dlw_pkg::OP_LAUNCH, 7'd0,   7'd127, dlw_pkg::DIR_DOWN,  1'b1,
      '{dlw_pkg::STAT_BLOCKED, 7'd0,   7'd127, 7'd10}},
    '{dlw_pkg::OP_LAUNCH, 7'd64,  7'd64,  dlw_pkg::DIR_UP,    1'b1,
      '{dlw_pkg::STAT_BLOCKED, 7'd64,  7'd64,  7'd10}},
    '{dlw_pkg::OP_STEP,   7'd5,   7'd9,   dlw_pkg::DIR_LEFT,  1'b1,
      '{dlw_pkg::STAT_IDLE,    7'd64,  7'd64,  7'd10}},
    '{dlw_pkg::OP_LAUNCH, 7'd64,  7'd66,  dlw_pkg::DIR_UP,    1'b0, NO_FIXED},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_DOWN,  1'b0, NO_FIXED},
    '{dlw_pkg::OP_LAUNCH, 7'd65,  7'd64,  dlw_pkg::DIR_UP,    1'b0, NO_FIXED},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_LEFT,  1'b0, NO_FIXED},
    '{dlw_pkg::OP_LAUNCH, 7'd1,   7'd50,  dlw_pkg::DIR_UP,    1'b0, NO_FIXED},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_LEFT,  1'b1,
      '{dlw_pkg::STAT_ESCAPED, 7'd0,   7'd50,  7'd10}},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_UP,    1'b1,
      '{dlw_pkg::STAT_IDLE,    7'd0,   7'd50,  7'd10}},
    '{dlw_pkg::OP_LAUNCH, 7'd126, 7'd10,  dlw_pkg::DIR_UP,    1'b0, NO_FIXED},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_RIGHT, 1'b1,
      '{dlw_pkg::STAT_ESCAPED, 7'd127, 7'd10,  7'd10}},
    '{dlw_pkg::OP_LAUNCH, 7'd10,  7'd126, dlw_pkg::DIR_UP,    1'b0, NO_FIXED},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_UP,    1'b1,
      '{dlw_pkg::STAT_ESCAPED, 7'd10,  7'd127, 7'd10}},
    '{dlw_pkg::OP_LAUNCH, 7'd10,  7'd1,   dlw_pkg::DIR_UP,    1'b0, NO_FIXED},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_DOWN,  1'b1,
      '{dlw_pkg::STAT_ESCAPED, 7'd10,  7'd0,   7'd10}},
    '{dlw_pkg::OP_LAUNCH, 7'd30,  7'd30,  dlw_pkg::DIR_UP,    1'b0, NO_FIXED},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_UP,    1'b0, NO_FIXED},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_RIGHT, 1'b0, NO_FIXED},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_DOWN,  1'b0, NO_FIXED},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_LEFT,  1'b0, NO_FIXED},
    '{dlw_pkg::OP_LAUNCH, 7'd126, 7'd126, dlw_pkg::DIR_UP,    1'b0, NO_FIXED},
    '{dlw_pkg::OP_STEP,   7'd0,   7'd0,   dlw_pkg::DIR_RIGHT, 1'b0, NO_FIXED}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [dlw_pkg::ADDR_W-1:0]     paddr = '0;
  logic [dlw_pkg::DATA_W-1:0]     pwdata = '0;
  logic [dlw_pkg::DATA_W-1:0]     prdata;
  logic                           pready;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           op = dlw_pkg::OP_LAUNCH;
  logic [dlw_pkg::COORD_W-1:0]    pos_x = '0;
  logic [dlw_pkg::COORD_W-1:0]    pos_y = '0;
  logic [1:0]                     direction = dlw_pkg::DIR_UP;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [dlw_pkg::STATUS_W-1:0]   status;
  logic [dlw_pkg::COORD_W-1:0]    walker_col;
  logic [dlw_pkg::COORD_W-1:0]    walker_row;
  logic [dlw_pkg::RADIUS_W-1:0]   launch_radius;

  dla_lattice_walker dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .direction     (direction),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .walker_col    (walker_col),
    .walker_row    (walker_row),
    .launch_radius (launch_radius)
  );

  // walker model state
  bit                             cluster_map [EXT][EXT];
  int                             cl_x [$];
  int                             cl_y [$];
  logic [dlw_pkg::COORD_W-1:0]    wk_x;
  logic [dlw_pkg::COORD_W-1:0]    wk_y;
  bit                             wk_live;
  logic [dlw_pkg::INTERVAL_W-1:0] launches;
  logic [dlw_pkg::INTERVAL_W-1:0] interval_q;
  logic [dlw_pkg::START_W-1:0]    start_q;
  logic [dlw_pkg::RADIUS_W-1:0]   radius_q;

  walk_result_t          results_due [$];
  int                    errors = 0;
  int                    burst_left = 0;
  bit                    hold_req = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit is_cluster(int x, int y);
    if (x < 0 || y < 0 || x >= EXT || y >= EXT) return 1'b0;
    return cluster_map[y][x];
  endfunction

  function automatic bit at_border(int x, int y);
    return x == 0 || y == 0 || x >= EXT - 1 || y >= EXT - 1;
  endfunction

  function automatic void grow_cluster(int x, int y);
    if (x < EXT && y < EXT && !cluster_map[y][x]) begin
      cluster_map[y][x] = 1'b1;
      cl_x.push_back(x);
      cl_y.push_back(y);
    end
  endfunction

  function automatic void lattice_clear();
    foreach (cluster_map[j, i]) cluster_map[j][i] = 1'b0;
    cl_x.delete();
    cl_y.delete();
    grow_cluster(EXT / 2, EXT / 2);
    wk_x = '0;
    wk_y = '0;
    wk_live = 1'b0;
    launches = '0;
    start_q = dlw_pkg::DEF_START_RADIUS;
    interval_q = dlw_pkg::DEF_GROWTH_INTERVAL;
    radius_q = dlw_pkg::RADIUS_W'(dlw_pkg::DEF_START_RADIUS);
  endfunction

  function automatic walk_result_t walk_predict(logic op_i, logic [dlw_pkg::COORD_W-1:0] x_i,
                                                logic [dlw_pkg::COORD_W-1:0] y_i,
                                                logic [1:0] d_i);
    walk_result_t r;
    int nx;
    int ny;
    r = '0;
    if (op_i == dlw_pkg::OP_LAUNCH) begin
      wk_x = x_i;
      wk_y = y_i;
      if (at_border(x_i, y_i) || is_cluster(x_i, y_i)) begin
        wk_live = 1'b0;
        r.status = dlw_pkg::STAT_BLOCKED;
      end else begin
        wk_live = 1'b1;
        r.status = dlw_pkg::STAT_LAUNCHED;
      end
      launches = launches + dlw_pkg::INTERVAL_W'(1);
      if (interval_q != 0 && launches >= interval_q) begin
        launches = '0;
        if (radius_q < EXT / 2) radius_q = radius_q + dlw_pkg::RADIUS_W'(1);
      end
    end else if (!wk_live) begin
      r.status = dlw_pkg::STAT_IDLE;
    end else begin
      nx = wk_x;
      ny = wk_y;
      case (d_i)
        dlw_pkg::DIR_UP:    ny = ny + 1;
        dlw_pkg::DIR_RIGHT: nx = nx + 1;
        dlw_pkg::DIR_DOWN:  ny = ny - 1;
        default:            nx = nx - 1;
      endcase
      nx = nx & 8'h7f;
      ny = ny & 8'h7f;
      if (is_cluster(nx, ny)) begin
        grow_cluster(wk_x, wk_y);
        wk_live = 1'b0;
        r.status = dlw_pkg::STAT_STUCK;
      end else if (at_border(nx, ny)) begin
        wk_x = nx[dlw_pkg::COORD_W-1:0];
        wk_y = ny[dlw_pkg::COORD_W-1:0];
        wk_live = 1'b0;
        r.status = dlw_pkg::STAT_ESCAPED;
      end else begin
        wk_x = nx[dlw_pkg::COORD_W-1:0];
        wk_y = ny[dlw_pkg::COORD_W-1:0];
        if (is_cluster(nx - 1, ny) || is_cluster(nx + 1, ny) ||
            is_cluster(nx, ny - 1) || is_cluster(nx, ny + 1)) begin
          grow_cluster(nx, ny);
          wk_live = 1'b0;
          r.status = dlw_pkg::STAT_STUCK;
        end else begin
          r.status = dlw_pkg::STAT_MOVING;
        end
      end
    end
    r.col = wk_x;
    r.row = wk_y;
    r.radius = radius_q;
    return r;
  endfunction

  task automatic send_item(logic op_i, logic [dlw_pkg::COORD_W-1:0] x_i,
                           logic [dlw_pkg::COORD_W-1:0] y_i, logic [1:0] d_i,
                           bit fixed = 1'b0, walk_result_t fixed_res = '0);
    int gap;
    walk_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    op        <= op_i;
    pos_x     <= x_i;
    pos_y     <= y_i;
    direction <= d_i;
    do @(posedge clk); while (!in_ready);
    r = walk_predict(op_i, x_i, y_i, d_i);
    results_due.push_back(fixed ? fixed_res : r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [dlw_pkg::DATA_W-1:0] val);
    logic [dlw_pkg::DATA_W-1:0] back;
    logic [dlw_pkg::DATA_W-1:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == dlw_pkg::REG_START_RADIUS) begin
      start_q  = val[dlw_pkg::START_W-1:0];
      radius_q = (start_q == 0) ? dlw_pkg::RADIUS_W'(1) : dlw_pkg::RADIUS_W'(start_q);
      want     = dlw_pkg::DATA_W'(start_q);
    end else begin
      interval_q = val[dlw_pkg::INTERVAL_W-1:0];
      want       = dlw_pkg::DATA_W'(interval_q);
    end
    // read back in the following transaction
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    back = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back !== want) begin
      errors++;
      if (errors <= 10)
        $display("register %0d read back %0h, expected %0h", idx, back, want);
    end
  endtask

  task automatic run_walks(int n_items);
    int sent;
    int pick;
    int tx;
    int ty;
    int lx;
    int ly;
    int dx;
    int dy;
    int k;
    int n_steps;
    logic [1:0] d;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99, 0) < 72) begin
        pick = $urandom_range(cl_x.size() - 1, 0);
        tx = cl_x[pick];
        ty = cl_y[pick];
        k = $urandom_range(19, 0);
        if (k < 2) begin
          lx = tx;
          ly = ty;
        end else if (k < 6) begin
          lx = $urandom_range(EXT - 2, 1);
          ly = $urandom_range(EXT - 2, 1);
          if ($urandom_range(1, 0)) lx = $urandom_range(1, 0) ? 1 : EXT - 2;
          else ly = $urandom_range(1, 0) ? 1 : EXT - 2;
        end else begin
          lx = tx + int'($urandom_range(8, 0)) - 4;
          ly = ty + int'($urandom_range(8, 0)) - 4;
          if (lx == tx && ly == ty) lx = lx + 1;
          if (lx < 0) lx = 0;
          if (ly < 0) ly = 0;
          if (lx > EXT - 1) lx = EXT - 1;
          if (ly > EXT - 1) ly = EXT - 1;
        end
        send_item(dlw_pkg::OP_LAUNCH, lx[dlw_pkg::COORD_W-1:0], ly[dlw_pkg::COORD_W-1:0],
                  2'($urandom));
        sent++;
        n_steps = 0;
        while (wk_live && n_steps < 80 && sent < n_items) begin
          dx = tx - int'(wk_x);
          dy = ty - int'(wk_y);
          if ($urandom_range(1, 0) || (dx == 0 && dy == 0)) begin
            d = 2'($urandom);
          end else if (dx != 0 && (dy == 0 || $urandom_range(1, 0))) begin
            d = (dx > 0) ? dlw_pkg::DIR_RIGHT : dlw_pkg::DIR_LEFT;
          end else begin
            d = (dy > 0) ? dlw_pkg::DIR_UP : dlw_pkg::DIR_DOWN;
          end
          send_item(dlw_pkg::OP_STEP, 7'($urandom), 7'($urandom), d);
          sent++;
          n_steps++;
        end
      end else begin
        send_item(1'($urandom), 7'($urandom), 7'($urandom), 2'($urandom));
        sent++;
      end
    end
  endtask

  task automatic run_phase(logic [dlw_pkg::DATA_W-1:0] start_val,
                           logic [dlw_pkg::DATA_W-1:0] interval_val, bit hold);
    wait_drained();
    repeat (8) @(posedge clk);
    reg_write(dlw_pkg::REG_START_RADIUS, start_val | ($urandom << dlw_pkg::START_W));
    reg_write(dlw_pkg::REG_GROWTH_INTERVAL, interval_val | ($urandom << dlw_pkg::INTERVAL_W));
    if (hold) hold_req = 1'b1;
    run_walks(100);
    wait_drained();
    run_walks(105);
  endtask

  // result side stall pattern
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(3, 0);
      span = $urandom_range(200, 20);
      repeat (span) begin
        @(negedge clk);
        if (hold_req) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom);
            2:       out_ready <= ($urandom_range(3, 0) == 0);
            default: out_ready <= ~out_ready;
          endcase
        end
      end
    end
  end

  initial begin
    walk_result_t want;
    walk_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = '{status, walker_col, walker_row, launch_radius};
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result with nothing expected: status %0d col %0d row %0d radius %0d",
                     got.status, got.col, got.row, got.radius);
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status || got.col !== want.col ||
              got.row !== want.row || got.radius !== want.radius) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: status %0d/%0d col %0d/%0d row %0d/%0d radius %0d/%0d",
                       got.status, want.status, got.col, want.col,
                       got.row, want.row, got.radius, want.radius);
          end
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    lattice_clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (PLAN[i])
      send_item(PLAN[i].op, PLAN[i].x, PLAN[i].y, PLAN[i].dir, PLAN[i].fixed, PLAN[i].res);

    run_phase(32'd63, 32'd1, 1'b1);
    run_phase(32'd0, 32'd0, 1'b0);
    run_phase(32'd1, 32'd65535, 1'b0);
    run_phase(32'($urandom_range(63, 1)), 32'($urandom_range(25, 2)), 1'b1);
    run_phase(32'($urandom_range(63, 1)), 32'd300, 1'b0);
    run_phase(32'($urandom_range(63, 1)), 32'd1, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
